// ----- rtl/rrts_pkg.sv -----
package rrts_pkg;

  localparam int MAX_THREADS = 16;
  localparam int ID_W        = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_TICK   = 3'd1;
  localparam logic [2:0] CMD_EXIT   = 3'd2;
  localparam logic [2:0] CMD_BLOCK  = 3'd3;
  localparam logic [2:0] CMD_UNLOCK = 3'd4;
  localparam logic [2:0] CMD_JOIN   = 3'd5;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NO_FREE = 2'd1;
  localparam logic [1:0] STS_NOT_FIN = 2'd2;
  localparam logic [1:0] STS_NONE    = 2'd3;

  typedef struct packed {
    logic       exec;
    logic       drain;
    logic [2:0] op;
  } ctl_cmd_t;

  typedef struct packed {
    logic blocked_empty;
  } ctl_sts_t;

endpackage

// ----- rtl/round_robin_thread_scheduler.sv -----
// Round-robin thread scheduler for sixteen thread ids.
// Input channel: in_valid/in_ready with in_command and in_target_id; one
// transaction is one command. Result channel: out_valid/out_ready with the
// status, running thread, allocated id, switch flag and ready count; every
// command gives exactly one result.
// Create, tick, exit, block and join are applied in the cycle they are
// taken and their result is valid on the next cycle. Unlock moves the
// blocked ring to the ready ring one entry per cycle, then rotates once
// the blocked ring is empty and the output register is free.
// Throughput: one command per cycle for all but unlock, while the receiver
// takes each result; no new command is taken while an unlock is draining.
// The result sits in an output register; a new command is taken while the
// previous result is being taken in the same cycle. When the receiver
// stalls, the result holds and in_ready drops until it is taken.
// Reset (rst_n low, synchronous): thread 0 runs and is the only id in use,
// both rings are empty, no id is finished and no result is pending.
module round_robin_thread_scheduler
  import rrts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_command,
  input  logic [ID_W-1:0]  in_target_id,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [ID_W-1:0]  out_running_id,
  output logic             out_running_present,
  output logic [ID_W-1:0]  out_new_id,
  output logic             out_switched,
  output logic [CNT_W-1:0] out_ready_count
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  rrts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rrts_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .target_id           (in_target_id),
    .sts                 (sts),
    .out_status          (out_status),
    .out_running_id      (out_running_id),
    .out_running_present (out_running_present),
    .out_new_id          (out_new_id),
    .out_switched        (out_switched),
    .out_ready_count     (out_ready_count)
  );

endmodule

// ----- rtl/rrts_ctrl.sv -----
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_command,
  output logic       out_valid,
  input  logic       out_ready,
  input  ctl_sts_t   sts,
  output ctl_cmd_t   cmd
);

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.exec  = 1'b0;
    cmd.drain = 1'b0;
    cmd.op    = in_command;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // unlock first empties the blocked ring, then rotates
          if (in_command == CMD_UNLOCK) begin
            state_nxt = S_DRAIN;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        cmd.op = CMD_UNLOCK;
        if (!sts.blocked_empty) begin
          cmd.drain = 1'b1;
        end else if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> !in_ready)
    else $error("input taken while draining blocked ring");
  a_exec_frees_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> out_free)
    else $error("result overwrites an untaken transaction");
  a_drain_ends_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN && state_nxt == S_IDLE |-> cmd.exec && sts.blocked_empty)
    else $error("unlock left without its rotate");
`endif

endmodule

// ----- rtl/rrts_dp.sv -----
module rrts_dp
  import rrts_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  ctl_cmd_t        cmd,
  input  logic [ID_W-1:0] target_id,
  output ctl_sts_t        sts,
  output logic [1:0]      out_status,
  output logic [ID_W-1:0] out_running_id,
  output logic            out_running_present,
  output logic [ID_W-1:0] out_new_id,
  output logic            out_switched,
  output logic [CNT_W-1:0] out_ready_count
);

  logic [ID_W-1:0]        cur_r, cur_nxt;
  logic                   pres_r, pres_nxt;
  logic [ID_W-1:0]        rhead_r, rhead_nxt;
  logic [CNT_W-1:0]       rfill_r, rfill_nxt;
  logic [ID_W-1:0]        bhead_r, bhead_nxt;
  logic [CNT_W-1:0]       bfill_r, bfill_nxt;
  logic [MAX_THREADS-1:0] fin_r, fin_nxt;
  logic [MAX_THREADS-1:0] use_r, use_nxt;
  logic [ID_W-1:0]        rring_r [MAX_THREADS];
  logic [ID_W-1:0]        bring_r [MAX_THREADS];

  logic [1:0]             status_r;
  logic [ID_W-1:0]        run_id_r;
  logic                   run_pres_r;
  logic [ID_W-1:0]        new_id_r;
  logic                   switched_r;
  logic [CNT_W-1:0]       count_r;

  logic                   rwe;
  logic [ID_W-1:0]        rwdata;
  logic [ID_W-1:0]        rtail;
  logic                   bwe;
  logic [ID_W-1:0]        btail;
  logic                   rfull;
  logic                   bfull;
  logic                   free_found;
  logic [ID_W-1:0]        free_id;
  logic                   rot;
  logic                   disp;
  logic [1:0]             st;
  logic [ID_W-1:0]        nid;

  assign rtail = rhead_r + rfill_r[ID_W-1:0];
  assign btail = bhead_r + bfill_r[ID_W-1:0];
  assign rfull = (rfill_r == CNT_W'(MAX_THREADS));
  assign bfull = (bfill_r == CNT_W'(MAX_THREADS));
  assign sts.blocked_empty = (bfill_r == '0);

  // lowest unused id
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (!use_r[i]) begin
        free_found = 1'b1;
        free_id    = ID_W'(i);
      end
    end
  end

  always_comb begin
    cur_nxt   = cur_r;
    pres_nxt  = pres_r;
    rhead_nxt = rhead_r;
    rfill_nxt = rfill_r;
    bhead_nxt = bhead_r;
    bfill_nxt = bfill_r;
    fin_nxt   = fin_r;
    use_nxt   = use_r;
    rwe       = 1'b0;
    rwdata    = cur_r;
    bwe       = 1'b0;
    rot       = 1'b0;
    disp      = 1'b0;
    st        = STS_OK;
    nid       = '0;

    if (cmd.drain) begin
      // one blocked entry moves to the back of ready
      if (!rfull) begin
        rwe       = 1'b1;
        rwdata    = bring_r[bhead_r];
        rfill_nxt = rfill_r + 1'b1;
      end
      bhead_nxt = bhead_r + 1'b1;
      bfill_nxt = bfill_r - 1'b1;
    end else if (cmd.exec) begin
      case (cmd.op) inside
        CMD_CREATE: begin
          if (free_found) begin
            use_nxt[free_id] = 1'b1;
            nid              = free_id;
            if (!rfull) begin
              rwe       = 1'b1;
              rwdata    = free_id;
              rfill_nxt = rfill_r + 1'b1;
            end
          end else begin
            st = STS_NO_FREE;
          end
        end
        CMD_TICK, CMD_UNLOCK: rot = 1'b1;
        CMD_EXIT: begin
          if (pres_r) begin
            fin_nxt[cur_r] = 1'b1;
          end
          disp = 1'b1;
        end
        CMD_BLOCK: begin
          if (pres_r && !bfull) begin
            bwe       = 1'b1;
            bfill_nxt = bfill_r + 1'b1;
          end
          disp = 1'b1;
        end
        CMD_JOIN: begin
          if (fin_r[target_id]) begin
            fin_nxt[target_id] = 1'b0;
            use_nxt[target_id] = 1'b0;
          end else begin
            st  = STS_NOT_FIN;
            rot = 1'b1;
          end
        end
        default: ;
      endcase

      if (rot || disp) begin
        if (rfill_r != '0) begin
          cur_nxt   = rring_r[rhead_r];
          pres_nxt  = 1'b1;
          rhead_nxt = rhead_r + 1'b1;
          // requeued thread is written at the tail, so the fill count is unchanged
          if (rot && pres_r) begin
            rwe    = 1'b1;
            rwdata = cur_r;
          end else begin
            rfill_nxt = rfill_r - 1'b1;
          end
        end else if (disp) begin
          pres_nxt = 1'b0;
        end
      end

      if (st == STS_OK && !pres_nxt) begin
        st = STS_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      pres_r  <= 1'b1;
      rhead_r <= '0;
      rfill_r <= '0;
      bhead_r <= '0;
      bfill_r <= '0;
      fin_r   <= '0;
      use_r   <= MAX_THREADS'(1);
    end else begin
      cur_r   <= cur_nxt;
      pres_r  <= pres_nxt;
      rhead_r <= rhead_nxt;
      rfill_r <= rfill_nxt;
      bhead_r <= bhead_nxt;
      bfill_r <= bfill_nxt;
      fin_r   <= fin_nxt;
      use_r   <= use_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rwe) begin
      rring_r[rtail] <= rwdata;
    end
    if (bwe) begin
      bring_r[btail] <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r   <= st;
      run_id_r   <= pres_nxt ? cur_nxt : '0;
      run_pres_r <= pres_nxt;
      new_id_r   <= nid;
      switched_r <= (pres_r != pres_nxt) || (pres_nxt && (cur_r != cur_nxt));
      count_r    <= rfill_nxt;
    end
  end

  assign out_status          = status_r;
  assign out_running_id      = run_id_r;
  assign out_running_present = run_pres_r;
  assign out_new_id          = new_id_r;
  assign out_switched        = switched_r;
  assign out_ready_count     = count_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rfill_r <= CNT_W'(MAX_THREADS) && bfill_r <= CNT_W'(MAX_THREADS))
    else $error("ring fill beyond depth");
  a_running_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    pres_r |-> use_r[cur_r] && !fin_r[cur_r])
    else $error("running thread not live");
  a_finished_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r & ~use_r) == '0)
    else $error("finished id not marked in use");
`endif

endmodule
